FILE: rtl/cts_pkg.sv
// Shared constants and types for the Carmichael function search unit.
package cts_pkg;
    localparam int MOD_WIDTH   = 12;
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);
    localparam int CNT_WIDTH   = MOD_WIDTH + 1;
    typedef logic [MOD_WIDTH-1:0] t_res;
endpackage

FILE: rtl/cts_if.sv
// Valid/ready channel carrying one modulus or one result item.
interface cts_if;
    import cts_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cts_ram.sv
// Generic single-port RAM with registered read.
module cts_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One read per cycle, and one write in the same cycle when i_we is high.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: rtl/cts_divmod.sv
// Bit-serial remainder unit: a mod b, one quotient bit per cycle.
module cts_divmod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [2*cts_pkg::MOD_WIDTH-1:0] i_num,
    input  logic [cts_pkg::MOD_WIDTH-1:0]   i_den,
    output logic                   o_done,
    output logic [cts_pkg::MOD_WIDTH-1:0]   o_rem
);
    import cts_pkg::*;
    localparam int NW = 2 * MOD_WIDTH;
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0]        r_num;
    logic [MOD_WIDTH:0]   r_rem;
    logic [MOD_WIDTH-1:0] r_den;
    logic [SW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MOD_WIDTH+1:0] n_shift;
    logic [MOD_WIDTH+1:0] n_diff;

    // Shift in the next numerator bit and subtract when it fits.
    always_comb begin
        n_shift = {r_rem, r_num[NW-1]};
        n_diff  = n_shift - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= SW'(NW);
            end else if (r_busy) begin
                r_num <= {r_num[NW-2:0], 1'b0};
                if (!n_diff[MOD_WIDTH+1]) begin
                    r_rem <= n_diff[MOD_WIDTH:0];
                end else begin
                    r_rem <= n_shift[MOD_WIDTH:0];
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_rem  = r_rem[MOD_WIDTH-1:0];
endmodule

FILE: rtl/carmichael_totient_search_unit.sv
// Top level of the Carmichael function search unit.
// Usage: a modulus n arrives as one item on i_in; one result item,
// lambda(n), leaves on o_out. One item is worked at a time; i_in.ready
// is high only while the unit is idle and its output register is empty.
// n of 2 or less answers with 1 and skips the gcd phase. Otherwise a gcd
// phase runs a Euclid loop for every k in 1..n, each step built around a
// 24-bit serial remainder, and writes the coprimes into a coprime RAM.
// A prime n answers right after that phase. Otherwise each pass over the
// held coprimes does one serial modular multiply per entry, using the
// remainder unit and the one-port RAM accesses, up to lambda passes. A
// 12-bit modulus that is a prime square, such as 3721, needs thousands
// of passes.
// Reset (synchronous, active low) returns to idle and empties the output
// register; RAM contents are left as they are, every entry is written
// before it is read. When the receiver stalls the result waits in the
// output register and no new modulus is taken until it leaves.
module carmichael_totient_search_unit (
    input logic i_clk,
    input logic i_rst_n,
    cts_if.sink   i_in,
    cts_if.source o_out
);
    import cts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_GCD_START, S_GCD_WAIT, S_GCD_NEXT, S_COPY_RD, S_COPY_WR,
        S_PW_RD_C, S_PW_RD_P, S_PW_MUL, S_PW_WAIT, S_PW_NEXT, S_DONE
    } t_state;

    t_state                r_state;
    t_res                  r_n, r_a, r_b, r_k, r_pw, r_res;
    logic [CNT_WIDTH-1:0]  r_count, r_held, r_idx;
    logic                  r_allone, r_ovalid;
    logic [2*MOD_WIDTH-1:0] r_prod;

    logic       c_we, p_we, dv_start, dv_done;
    logic [ADDR_WIDTH-1:0] c_addr, p_addr;
    t_res       c_wdata, p_wdata, c_rdata, p_rdata, dv_rem, dv_den;
    logic [2*MOD_WIDTH-1:0] dv_num;

    cts_ram #(.WIDTH(MOD_WIDTH), .DEPTH(STORE_DEPTH)) u_coprime (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wdata),
        .o_rdata(c_rdata));
    cts_ram #(.WIDTH(MOD_WIDTH), .DEPTH(STORE_DEPTH)) u_power (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr), .i_wdata(p_wdata),
        .o_rdata(p_rdata));
    cts_divmod u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(dv_num),
        .i_den(dv_den), .o_done(dv_done), .o_rem(dv_rem));

    // Memory and divider control decoded from the state.
    always_comb begin
        c_we     = 1'b0;
        p_we     = 1'b0;
        c_addr   = r_idx[ADDR_WIDTH-1:0];
        p_addr   = r_idx[ADDR_WIDTH-1:0];
        c_wdata  = r_k;
        p_wdata  = c_rdata;
        dv_start = 1'b0;
        dv_num   = {{MOD_WIDTH{1'b0}}, r_a};
        dv_den   = r_b;
        unique case (r_state)
            S_GCD_START: dv_start = (r_b != '0);
            S_GCD_NEXT: begin
                c_addr = r_held[ADDR_WIDTH-1:0];
                c_we   = (r_b == '0) && (r_a == t_res'(1))
                         && (r_held < CNT_WIDTH'(STORE_DEPTH));
            end
            S_COPY_WR:   p_we = 1'b1;
            S_PW_MUL: begin
                dv_start = 1'b1;
                dv_num   = r_prod;
                dv_den   = r_n;
            end
            S_PW_NEXT: begin
                p_we    = 1'b1;
                p_wdata = dv_rem;
            end
            default: ;
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    // Sequencer for the gcd, copy and power phases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_n     <= i_in.data;
                        r_count <= '0;
                        r_held  <= '0;
                        r_k     <= t_res'(1);
                        r_a     <= i_in.data;
                        r_b     <= t_res'(1);
                        if (i_in.data <= t_res'(2)) begin
                            r_res   <= t_res'(1);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_GCD_START;
                        end
                    end
                end
                S_GCD_START: begin
                    r_state <= (r_b == '0) ? S_GCD_NEXT : S_GCD_WAIT;
                end
                S_GCD_WAIT: begin
                    if (dv_done) begin
                        r_a     <= r_b;
                        r_b     <= dv_rem;
                        r_state <= S_GCD_START;
                    end
                end
                S_GCD_NEXT: begin
                    if (r_a == t_res'(1)) begin
                        r_count <= r_count + 1'b1;
                        if (c_we) begin
                            r_held <= r_held + 1'b1;
                        end
                    end
                    if (r_k == r_n) begin
                        r_idx <= '0;
                        if ({1'b0, r_count + CNT_WIDTH'(r_a == t_res'(1))}
                                == {1'b0, CNT_WIDTH'(r_n)} - 1'b1) begin
                            r_res   <= r_n - 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_COPY_RD;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_a     <= r_n;
                        r_b     <= r_k + 1'b1;
                        r_state <= S_GCD_START;
                    end
                end
                S_COPY_RD: begin
                    if (r_idx == r_held) begin
                        r_pw     <= t_res'(2);
                        r_idx    <= '0;
                        r_allone <= 1'b1;
                        r_state  <= (r_count > CNT_WIDTH'(2)) ? S_PW_RD_C : S_DONE;
                        r_res    <= t_res'(2);
                    end else begin
                        r_state <= S_COPY_WR;
                    end
                end
                S_COPY_WR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_COPY_RD;
                end
                S_PW_RD_C: begin
                    if (r_idx == r_held) begin
                        if (r_allone || CNT_WIDTH'(r_pw) + 1'b1 >= r_count) begin
                            r_res   <= r_allone ? r_pw : t_res'(r_count);
                            r_state <= S_DONE;
                        end else begin
                            r_pw     <= r_pw + 1'b1;
                            r_idx    <= '0;
                            r_allone <= 1'b1;
                        end
                    end else begin
                        r_state <= S_PW_RD_P;
                    end
                end
                S_PW_RD_P: begin
                    // Product of the coprime entry and its running power.
                    r_prod  <= {{MOD_WIDTH{1'b0}}, c_rdata}
                               * {{MOD_WIDTH{1'b0}}, p_rdata};
                    r_state <= S_PW_MUL;
                end
                S_PW_MUL: begin
                    r_state <= S_PW_WAIT;
                end
                S_PW_WAIT: begin
                    if (dv_done) begin
                        r_state <= S_PW_NEXT;
                    end
                end
                S_PW_NEXT: begin
                    if (dv_rem != t_res'(1)) begin
                        r_allone <= 1'b0;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_PW_RD_C;
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The result valid flag only rises after the done state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_res))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE)
        else $error("accepted while busy");
endmodule
